@@ rtl/nlc_pkg.sv @@
`default_nettype none

package nlc_pkg;

    // Field widths
    localparam int TICK_WIDTH = 8;
    localparam int CTL_W      = 8;
    localparam int WORD_W     = 16;
    localparam int DONE_W     = 5;
    localparam int LEVEL_W    = 2;
    localparam int CD_W       = 24;

    // Work queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Control register layout
    localparam int NARROW_BIT = 3;
    localparam int CODE_LSB   = 0;
    localparam int CODE_MSB   = 2;
    localparam int SHIFT_LSB  = 4;
    localparam int SHIFT_MSB  = 7;

    // Shift register taps
    localparam int TAP_NARROW = 1;
    localparam int TAP_WIDE   = 7;
    localparam int FB_NARROW  = 7;
    localparam int FB_WIDE    = 15;

    localparam logic [WORD_W-1:0]         LFSR_ONES = '1;
    localparam logic [DONE_W-1:0]         DONE_MAX  = '1;
    localparam logic signed [LEVEL_W-1:0] LEVEL_NEG  = -2'sd1;
    localparam logic signed [LEVEL_W-1:0] LEVEL_POS  = 2'sd1;
    localparam logic signed [LEVEL_W-1:0] LEVEL_ZERO = 2'sd0;
    localparam logic [LEVEL_W-1:0]        LEVEL_BAD  = 2'b10;

    typedef enum logic
    {
        CMD_ADVANCE = 1'b0,
        CMD_TRIGGER = 1'b1
    } cmd_t;

    typedef enum logic
    {
        ST_IDLE  = 1'b0,
        ST_CLOCK = 1'b1
    } st_t;

    typedef struct packed
    {
        logic                  action;
        logic [TICK_WIDTH-1:0] ticks;
    } item_t;

    typedef struct packed
    {
        logic signed [LEVEL_W-1:0] level;
        logic [WORD_W-1:0]         shift_word;
        logic [DONE_W-1:0]         shifts_done;
    } result_t;

    typedef struct packed
    {
        cmd_t                  cmd;
        logic [TICK_WIDTH-1:0] ticks;
    } q_entry_t;

    typedef struct packed
    {
        logic              fb;
        logic [WORD_W-1:0] word;
    } lfsr_res_t;

    // Timer period: divisor shifted left by shift + 1
    function automatic logic [CD_W-1:0] period_of(input logic [CTL_W-1:0] ctl);
        logic [2:0] code;
        logic [7:0] div;
        logic [4:0] sh;
        code = ctl[CODE_MSB:CODE_LSB];
        div  = (code == 3'd0) ? 8'd8 : {1'b0, code, 4'b0000};
        sh   = {1'b0, ctl[SHIFT_MSB:SHIFT_LSB]} + 5'd1;
        return CD_W'(div) << sh;
    endfunction

    // One register clock: xor bit 0 with the tap, shift right, write feedback
    function automatic lfsr_res_t lfsr_step(input logic [WORD_W-1:0] s,
                                            input logic narrow);
        lfsr_res_t r;
        logic      x;
        x      = s[0] ^ (narrow ? s[TAP_NARROW] : s[TAP_WIDE]);
        r.word = s >> 1;
        if (narrow)
        begin
            r.word[FB_NARROW] = x;
        end
        else
        begin
            r.word[FB_WIDE] = x;
        end
        r.fb = x;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/noise_lfsr_channel_clock_top.sv @@
// Path: a beat is registered in the front holding stage, then in the two-entry queue;
// the back end registers a trigger's result directly, and for an advance beat subtracts
// the ticks and clocks the shift register once a cycle until the countdown is positive.
// The queue decouples the back end from the input; beats are taken while it has room.
// Reset (rst_n, asynchronous): register all ones, countdown zero, level zero,
// control zero, queue empty.
`default_nettype none

module noise_lfsr_channel_clock_top
    import nlc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [CTL_W-1:0] cfg_data,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire item_t            item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output result_t               result
);

    logic     push_valid;
    logic     push_ready;
    q_entry_t push_entry;
    logic     head_valid;
    q_entry_t head;
    logic     pop;

    nlc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    nlc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .pop        (pop),
        .head       (head)
    );

    nlc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ rtl/nlc_front.sv @@
`default_nettype none

module nlc_front
    import nlc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire item_t    item,
    output logic          push_valid,
    input  wire logic     push_ready,
    output q_entry_t      push_entry
);

    logic     valid_reg;
    logic     valid_next;
    q_entry_t entry_reg;
    q_entry_t entry_next;
    logic     accept;

    // Take a beat when the holding stage is empty or draining
    assign item_stall = valid_reg && !push_ready;
    assign accept     = item_valid && !item_stall;

    // Classify the beat into a command
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            if (item.action)
            begin
                entry_next.cmd   = CMD_TRIGGER;
                entry_next.ticks = '0;
            end
            else
            begin
                entry_next.cmd   = CMD_ADVANCE;
                entry_next.ticks = item.ticks;
            end
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

endmodule

`default_nettype wire

@@ rtl/nlc_queue.sv @@
`default_nettype none

module nlc_queue
    import nlc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire q_entry_t push_entry,
    output logic          head_valid,
    input  wire logic     pop,
    output q_entry_t      head
);

    q_entry_t          entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ rtl/nlc_back.sv @@
`default_nettype none

module nlc_back
    import nlc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [CTL_W-1:0] cfg_data,
    input  wire logic             head_valid,
    input  wire q_entry_t         head,
    output logic                  pop,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output result_t               result
);

    st_t                       state_reg;
    st_t                       state_next;
    logic [CTL_W-1:0]          ctl_reg;
    logic [CD_W-1:0]           period_reg;
    logic signed [CD_W-1:0]    cd_reg;
    logic signed [CD_W-1:0]    cd_next;
    logic [WORD_W-1:0]         shift_reg;
    logic [WORD_W-1:0]         shift_next;
    logic signed [LEVEL_W-1:0] level_reg;
    logic signed [LEVEL_W-1:0] level_next;
    logic [DONE_W-1:0]         done_reg;
    logic [DONE_W-1:0]         done_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    result_t                   out_reg;
    result_t                   out_next;
    logic signed [CD_W-1:0]    cd_sub;
    logic signed [CD_W-1:0]    cd_add;
    logic                      out_free;
    logic                      emit;
    lfsr_res_t                 step;

    // Countdown arithmetic for both paths
    assign cd_sub   = cd_reg - $signed(CD_W'(head.ticks));
    assign cd_add   = cd_reg + $signed(period_reg);
    assign step     = lfsr_step(shift_reg, ctl_reg[NARROW_BIT]);
    assign out_free = !out_valid_reg || !result_stall;

    // Sequence one command: load, subtract, then one register clock a cycle
    always_comb
    begin
        state_next = state_reg;
        cd_next    = cd_reg;
        shift_next = shift_reg;
        level_next = level_reg;
        done_next  = done_reg;
        emit       = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    pop       = 1'b1;
                    done_next = '0;
                    if (head.cmd == CMD_TRIGGER)
                    begin
                        shift_next = LFSR_ONES;
                        cd_next    = $signed(period_reg);
                        emit       = 1'b1;
                    end
                    else
                    begin
                        cd_next = cd_sub;
                        if (!cd_sub[CD_W-1] && (cd_sub != '0))
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_CLOCK;
                        end
                    end
                end
            end
            ST_CLOCK:
            begin
                cd_next    = cd_add;
                shift_next = step.word;
                level_next = step.fb ? LEVEL_NEG : LEVEL_POS;
                done_next  = (done_reg == DONE_MAX) ? done_reg : done_reg + 1'b1;
                if (!cd_add[CD_W-1] && (cd_add != '0))
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Load the result register; drop it once taken
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next       = 1'b1;
            out_next.level       = level_next;
            out_next.shift_word  = shift_next;
            out_next.shifts_done = done_next;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ctl_reg       <= '0;
            period_reg    <= '0;
            cd_reg        <= '0;
            shift_reg     <= LFSR_ONES;
            level_reg     <= LEVEL_ZERO;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            period_reg    <= period_of(ctl_reg);
            cd_reg        <= cd_next;
            shift_reg     <= shift_next;
            level_reg     <= level_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                ctl_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

@@ rtl/nlc_checker.sv @@
`default_nettype none

module nlc_checker
    import nlc_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    // Hold a stalled result beat
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // Level is -1, 0 or +1 only
    a_level_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.level != LEVEL_BAD)
        else $error("level out of range");

    // Zero level means the register was never clocked
    a_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.level == LEVEL_ZERO
            |-> result.shift_word == LFSR_ONES && result.shifts_done == '0)
        else $error("zero level after a register clock");

    // A clocked beat always carries a nonzero level
    a_clocked_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.shifts_done != '0 |-> result.level != LEVEL_ZERO)
        else $error("clocked beat with zero level");

endmodule

bind noise_lfsr_channel_clock_top nlc_checker u_nlc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

@@ dv/tb_noise_lfsr_channel_clock_top.sv @@
`timescale 1ns / 100ps

module tb_noise_lfsr_channel_clock_top;

    import nlc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_BEAT = 400;
    localparam int REPORT_MAX   = 10;
    localparam int DONE_SAT     = 31;

    typedef enum int
    {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE
    } stall_mode_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             cfg_write    = 1'b0;
    logic [CTL_W-1:0] cfg_data     = '0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    item_t            item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_t          result;

    // Beats waiting for the driver, and results the channel still owes
    item_t   pending_beats[$];
    result_t expected_noise[$];

    // Shadow of the channel state
    logic [CTL_W-1:0]          ctl_model   = '0;
    logic [WORD_W-1:0]         lfsr_model  = LFSR_ONES;
    int                        count_model = 0;
    logic signed [LEVEL_W-1:0] level_model = LEVEL_ZERO;

    int beats_in     = 0;
    int quiet_cycles = 0;
    int fail_cnt     = 0;
    int burst_left   = 1;
    int gap_left     = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;

    noise_lfsr_channel_clock_top u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Timer period: divisor (8, or 16 times the code) scaled by 2^(shift + 1)
    function automatic int timer_period(input logic [CTL_W-1:0] ctl);
        int divisor;
        int code;
        code    = int'(ctl[CODE_MSB:CODE_LSB]);
        divisor = (code == 0) ? 8 : 16 * code;
        return divisor << (int'(ctl[SHIFT_MSB:SHIFT_LSB]) + 1);
    endfunction

    // Apply one beat to the shadow state and form the result it yields
    task automatic predict_noise(input item_t b, output result_t r);
        int   per;
        int   clocks;
        logic fbit;
        logic narrow;
        per    = timer_period(ctl_model);
        clocks = 0;
        if (cmd_t'(b.action) == CMD_TRIGGER)
        begin
            lfsr_model  = LFSR_ONES;
            count_model = per;
        end
        else
        begin
            count_model -= int'(b.ticks);
            while (count_model <= 0)
            begin
                count_model += per;
                narrow = ctl_model[NARROW_BIT];
                fbit   = lfsr_model[0] ^ (narrow ? lfsr_model[TAP_NARROW]
                                                 : lfsr_model[TAP_WIDE]);
                lfsr_model = lfsr_model >> 1;
                if (narrow)
                begin
                    lfsr_model[FB_NARROW] = fbit;
                end
                else
                begin
                    lfsr_model[FB_WIDE] = fbit;
                end
                level_model = fbit ? LEVEL_NEG : LEVEL_POS;
                if (clocks < DONE_SAT)
                begin
                    clocks++;
                end
            end
        end
        r.level       = level_model;
        r.shift_word  = lfsr_model;
        r.shifts_done = clocks[DONE_W-1:0];
    endtask

    task automatic push_beat(input cmd_t c, input logic [TICK_WIDTH-1:0] t);
        item_t b;
        b.action = c;
        b.ticks  = t;
        pending_beats.push_back(b);
    endtask

    // Mostly advances with a bias toward the tick extremes, some restarts
    task automatic push_random_beat();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            push_beat(CMD_TRIGGER, TICK_WIDTH'($urandom));
        end
        else if (pick < 22)
        begin
            push_beat(CMD_ADVANCE, '1);
        end
        else if (pick < 30)
        begin
            push_beat(CMD_ADVANCE, '0);
        end
        else
        begin
            push_beat(CMD_ADVANCE, TICK_WIDTH'($urandom));
        end
    endtask

    // Hold until the driver is empty and every result has come back;
    // sample mid-cycle so the driver's outputs have settled
    task automatic wait_idle();
        while (pending_beats.size() != 0 || item_valid || expected_noise.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_control(input logic [CTL_W-1:0] v);
        wait_idle();
        cfg_data  <= v;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Input driver: bursts of beats separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else if (!(item_valid && item_stall))
        begin
            if (gap_left != 0)
            begin
                item_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end
            else if (pending_beats.size() != 0)
            begin
                item       <= pending_beats.pop_front();
                item_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Result stall: modes of random length plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (!hold_done && beats_in >= HOLD_AT_BEAT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(20, 150);
                end
                mode_left--;
                case (stall_mode)
                    STALL_NONE:      result_stall <= 1'b0;
                    STALL_LIGHT:     result_stall <= ($urandom_range(0, 99) < 30);
                    STALL_HEAVY:     result_stall <= ($urandom_range(0, 99) < 75);
                    default:         result_stall <= ~result_stall;
                endcase
            end
        end
    end

    // Track control writes, predict accepted beats, check accepted results
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                ctl_model = cfg_data;
            end
            if (item_valid && !item_stall)
            begin
                predict_noise(item, want);
                expected_noise.push_back(want);
                beats_in <= beats_in + 1;
            end
            if (result_valid && !result_stall)
            begin
                got = result;
                if (expected_noise.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                    begin
                        $display("unexpected result: level %0d word %h done %0d",
                                 got.level, got.shift_word, got.shifts_done);
                    end
                end
                else
                begin
                    want = expected_noise.pop_front();
                    if (got.level !== want.level || got.shift_word !== want.shift_word ||
                        got.shifts_done !== want.shifts_done)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX)
                        begin
                            $display("mismatch: level %0d/%0d word %h/%h done %0d/%0d",
                                     want.level, got.level, want.shift_word,
                                     got.shift_word, want.shifts_done, got.shifts_done);
                        end
                    end
                end
            end
        end
    end

    // Count cycles with no beat, result or control write
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
            cfg_write)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_noise_lfsr_channel_clock_top NOT OK");
        $finish;
    end

    initial
    begin
        int phase;
        int n;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset control, wide mode, period 16: level stays zero until a clock
        push_beat(CMD_TRIGGER, '1);
        push_beat(CMD_TRIGGER, '0);
        push_beat(CMD_ADVANCE, '0);
        push_beat(CMD_ADVANCE, 8'd15);
        push_beat(CMD_ADVANCE, 8'd1);
        push_beat(CMD_ADVANCE, 8'd16);
        push_beat(CMD_ADVANCE, 8'd17);
        push_beat(CMD_ADVANCE, '1);
        push_beat(CMD_ADVANCE, '1);
        push_beat(CMD_ADVANCE, 8'h80);
        push_beat(CMD_ADVANCE, 8'h55);
        push_beat(CMD_ADVANCE, 8'hAA);
        push_beat(CMD_ADVANCE, 8'd1);
        push_beat(CMD_ADVANCE, 8'd32);
        push_beat(CMD_TRIGGER, 8'h5A);
        push_beat(CMD_ADVANCE, '1);
        push_beat(CMD_ADVANCE, 8'hF0);
        push_beat(CMD_ADVANCE, '0);
        push_beat(CMD_TRIGGER, 8'hA5);
        push_beat(CMD_ADVANCE, 8'hFE);

        // Narrow mode, switched with the countdown mid-way
        write_control(8'h08);
        push_beat(CMD_ADVANCE, '1);
        push_beat(CMD_ADVANCE, '1);
        push_beat(CMD_TRIGGER, '0);
        push_beat(CMD_ADVANCE, '0);
        push_beat(CMD_ADVANCE, '1);

        // Random control settings with short periods so the register keeps moving
        for (phase = 0; phase < 12; phase++)
        begin
            write_control({4'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                           3'($urandom_range(0, 7))});
            for (n = 0; n < 140; n++)
            begin
                push_random_beat();
            end
        end

        // Largest divisor at the smallest shift, then the reset value
        write_control(8'h07);
        for (n = 0; n < 120; n++)
        begin
            push_random_beat();
        end
        write_control(8'h00);
        for (n = 0; n < 60; n++)
        begin
            push_random_beat();
        end

        // Longest periods last: a restart parks the countdown far out
        write_control(8'hF0);
        push_beat(CMD_TRIGGER, '1);
        for (n = 0; n < 19; n++)
        begin
            push_beat(CMD_ADVANCE, TICK_WIDTH'($urandom));
        end
        write_control(8'hFF);
        push_beat(CMD_TRIGGER, '0);
        for (n = 0; n < 19; n++)
        begin
            push_beat(CMD_ADVANCE, TICK_WIDTH'($urandom));
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0 && expected_noise.size() == 0)
        begin
            $display("tb_noise_lfsr_channel_clock_top OK");
        end
        else
        begin
            $display("tb_noise_lfsr_channel_clock_top NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/nlc_pkg.sv
rtl/nlc_front.sv
rtl/nlc_queue.sv
rtl/nlc_back.sv
rtl/noise_lfsr_channel_clock_top.sv
rtl/nlc_checker.sv
dv/tb_noise_lfsr_channel_clock_top.sv
